FILE: rtl/wds_pkg.sv
// Package for windowed_delay_stats: shared-unit opcodes, the unit control
// struct, register indexes, reset values and result field widths.
`default_nettype none

package wds_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_MUL  = 2'd0;
    localparam t_op OP_DIV  = 2'd1;
    localparam t_op OP_SQRT = 2'd2;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_ctl;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MEAN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_STDEV = 1'd1;

    localparam logic [CFG_DATA_W-1:0] DEFAULT_MEAN_RST  = 15'd280;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_STDEV_RST = 15'd100;

    localparam int DELAY_W     = 16;
    localparam int DELAY_MAG_W = 15;
    localparam int MEAN_FRAC   = 8;
    localparam int VAR_FRAC    = 16;
    localparam int RATE_FRAC   = 16;
    localparam int TYPO_COST   = 1000;

    localparam int MEAN_W  = 23;
    localparam int STDEV_W = 23;
    localparam int RATE_W  = 17;
    localparam int COST_W  = 21;
    localparam int HELD_W  = 7;

    localparam int OUT_BITS    = MEAN_W + STDEV_W + RATE_W + COST_W + HELD_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: rtl/wds_iter_unit.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit (or root digit) per cycle on one adder.
// Depends on wds_pkg.
`default_nettype none

module wds_iter_unit #(
    parameter int W = 60,
    localparam int IW = $clog2(W + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire wds_pkg::t_unit_ctl i_ctl,
    input  wire  [IW-1:0]           i_iters,
    input  wire  [W-1:0]            i_x,     // multiplicand / left-aligned dividend / radicand
    input  wire  [W-1:0]            i_y,     // multiplier / divisor
    output logic [W-1:0]            o_result,
    output logic                    o_done
);
    import wds_pkg::*;

    logic          r_busy;
    logic          r_done;
    t_op           r_op;
    logic [IW-1:0] r_cnt;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_acc;
    logic [W+1:0]  r_rem;

    logic [W+1:0]  s_a;
    logic [W+1:0]  s_b;
    logic          s_sub;
    logic [W+2:0]  s_sum;
    logic          s_ge;

    always_comb begin
        s_a   = '0;
        s_b   = '0;
        s_sub = 1'b0;
        case (r_op)
            OP_MUL: begin
                s_a = {2'b00, r_acc};
                s_b = {2'b00, r_x};
            end
            OP_DIV: begin
                s_a   = {r_rem[W:0], r_x[W-1]};
                s_b   = {2'b00, r_y};
                s_sub = 1'b1;
            end
            OP_SQRT: begin
                s_a   = {r_rem[W-1:0], r_x[W-1:W-2]};
                s_b   = {r_acc, 2'b01};
                s_sub = 1'b1;
            end
            default: begin
                s_a = '0;
            end
        endcase
        s_sum = {1'b0, s_a} + {1'b0, (s_sub ? ~s_b : s_b)} + {{(W+2){1'b0}}, s_sub};
        s_ge  = s_sum[W+2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == IW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_cnt <= i_iters;
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - IW'(1);
            case (r_op)
                OP_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= s_sum[W-1:0];
                    end
                    r_x <= r_x << 1;
                    r_y <= r_y >> 1;
                end
                OP_DIV: begin
                    r_x   <= r_x << 1;
                    r_rem <= s_ge ? s_sum[W+1:0] : s_a;
                    r_acc <= {r_acc[W-2:0], s_ge};
                end
                OP_SQRT: begin
                    r_x   <= r_x << 2;
                    r_rem <= s_ge ? s_sum[W+1:0] : s_a;
                    r_acc <= {r_acc[W-2:0], s_ge};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_result = r_acc;
    assign o_done   = r_done;

endmodule

`default_nettype wire

FILE: rtl/windowed_delay_stats.sv
// Top level of windowed_delay_stats: window store, sequencer and result
// register around the shared iterative unit. Depends on wds_pkg, wds_iter_unit.
//
// Keeps the last WINDOW keystroke delays and, for every input item, returns
// one result item: mean and sample deviation of the positive delays in Q8,
// typo fraction in Q1.16, cost and the number of held samples. The block takes
// one item at a time; o_s_tready is high only between items. The work for an
// item is set by the single shared adder, which does one multiplier bit,
// quotient bit or root digit per cycle: two 15-step squares, the mean divide
// (SW+8 steps), the variance products (2*CW+SW steps), the variance divide
// (NW+16 steps), the root (NW/2+8 steps) and the typo-rate divide (CW+16
// steps), where CW, SW and NW are the count, sum and product widths below;
// a dropped item skips the squares. A finished result waits in the output
// register while the next item is taken. The store needs no clearing after
// reset.
`default_nettype none

module windowed_delay_stats #(
    parameter int WINDOW = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [wds_pkg::DELAY_W-1:0]         i_s_tdata,  // [15:0] delay_value (signed)
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // [22:0] mean_q8, [45:23] stdev_q8, [62:46] typo_rate_q16,
    // [83:63] cost_centi, [90:84] held_samples, rest zero
    output logic [wds_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser,  // [0] accepted
    input  wire                                 i_cfg_we,
    input  wire  [wds_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [wds_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import wds_pkg::*;

    localparam int AW  = $clog2(WINDOW);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int SW  = DELAY_MAG_W + CW;
    localparam int SQW = 2 * DELAY_MAG_W + CW;
    localparam int NW  = CW + SQW;
    localparam int MW  = 2 * CW;
    localparam int QW  = NW + VAR_FRAC + (NW % 2);
    localparam int UW  = QW;
    localparam int IW  = $clog2(UW + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_RDOLD = 5'd2;
    localparam logic [4:0] S_EVICT = 5'd3;
    localparam logic [4:0] S_EVW   = 5'd4;
    localparam logic [4:0] S_ADD   = 5'd5;
    localparam logic [4:0] S_ADDW  = 5'd6;
    localparam logic [4:0] S_MEAN  = 5'd7;
    localparam logic [4:0] S_MEANW = 5'd8;
    localparam logic [4:0] S_NSQ   = 5'd9;
    localparam logic [4:0] S_NSQW  = 5'd10;
    localparam logic [4:0] S_SS    = 5'd11;
    localparam logic [4:0] S_SSW   = 5'd12;
    localparam logic [4:0] S_MM    = 5'd13;
    localparam logic [4:0] S_MMW   = 5'd14;
    localparam logic [4:0] S_VAR   = 5'd15;
    localparam logic [4:0] S_VARW  = 5'd16;
    localparam logic [4:0] S_SQRT  = 5'd17;
    localparam logic [4:0] S_SQRTW = 5'd18;
    localparam logic [4:0] S_RATE  = 5'd19;
    localparam logic [4:0] S_RATEW = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;

    logic [4:0]             r_state;
    logic [4:0]             n_state;

    logic [DELAY_W-1:0]     r_store [WINDOW];
    logic [DELAY_W-1:0]     r_rd_data;
    logic [AW-1:0]          s_rd_addr;

    logic [AW-1:0]          r_newest;
    logic [AW-1:0]          r_wpos;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_npos;
    logic [CW-1:0]          r_typo;
    logic [SW-1:0]          r_sum;
    logic [SQW-1:0]         r_sq;
    logic [CFG_DATA_W-1:0]  r_def_mean;
    logic [CFG_DATA_W-1:0]  r_def_stdev;

    logic [DELAY_W-1:0]     r_v;
    logic                   r_accepted;
    logic [MEAN_W-1:0]      r_mean;
    logic [STDEV_W-1:0]     r_stdev;
    logic [RATE_W-1:0]      r_rate;
    logic [NW-1:0]          r_t1;
    logic [NW-1:0]          r_num;
    logic [MW-1:0]          r_m;
    logic [QW-1:0]          r_q;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_user;

    logic                   s_full;
    logic                   s_drop;
    logic                   s_v_pos;
    logic                   s_old_pos;
    logic [AW-1:0]          s_prev_pos;
    logic                   s_out_room;
    logic [31:0]            s_cost32;
    logic [31:0]            s_held32;

    t_unit_ctl              s_ctl;
    logic [IW-1:0]          s_iters;
    logic [UW-1:0]          s_x;
    logic [UW-1:0]          s_y;
    logic [UW-1:0]          s_result;
    logic                   s_done;

    assign s_full     = (r_count == CW'(WINDOW));
    assign s_drop     = r_v[DELAY_W-1] && (r_count != '0) && r_rd_data[DELAY_W-1];
    assign s_v_pos    = !r_v[DELAY_W-1] && (r_v != '0);
    assign s_old_pos  = !r_rd_data[DELAY_W-1] && (r_rd_data != '0);
    assign s_prev_pos = (r_newest == '0) ? AW'(WINDOW - 1) : r_newest - AW'(1);
    assign s_rd_addr  = (r_state == S_IDLE) ? r_newest : r_wpos;
    assign s_out_room = !r_m_valid || i_m_tready;
    assign s_cost32   = 32'(r_sum) + 32'(r_typo) * 32'(TYPO_COST);
    assign s_held32   = 32'(r_count);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = S_CHK;
            S_CHK:   n_state = s_drop ? S_MEAN : (s_full ? S_RDOLD : S_ADD);
            S_RDOLD: n_state = S_EVICT;
            S_EVICT: n_state = s_old_pos ? S_EVW : S_ADD;
            S_EVW:   if (s_done) n_state = S_ADD;
            S_ADD:   n_state = s_v_pos ? S_ADDW : S_MEAN;
            S_ADDW:  if (s_done) n_state = S_MEAN;
            S_MEAN:  n_state = (r_npos != '0) ? S_MEANW : S_RATE;
            S_MEANW: if (s_done) n_state = (r_npos > CW'(1)) ? S_NSQ : S_RATE;
            S_NSQ:   n_state = S_NSQW;
            S_NSQW:  if (s_done) n_state = S_SS;
            S_SS:    n_state = S_SSW;
            S_SSW:   if (s_done) n_state = S_MM;
            S_MM:    n_state = S_MMW;
            S_MMW:   if (s_done) n_state = S_VAR;
            S_VAR:   n_state = S_VARW;
            S_VARW:  if (s_done) n_state = S_SQRT;
            S_SQRT:  n_state = S_SQRTW;
            S_SQRTW: if (s_done) n_state = S_RATE;
            S_RATE:  n_state = (r_count != '0) ? S_RATEW : S_DONE;
            S_RATEW: if (s_done) n_state = S_DONE;
            S_DONE:  if (s_out_room) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // launch operations on the shared unit
    always_comb begin
        s_ctl.start = 1'b0;
        s_ctl.op    = OP_MUL;
        s_iters     = '0;
        s_x         = '0;
        s_y         = '0;
        case (r_state)
            S_EVICT: begin
                s_ctl.start = s_old_pos;
                s_x         = UW'(r_rd_data[DELAY_MAG_W-1:0]);
                s_y         = UW'(r_rd_data[DELAY_MAG_W-1:0]);
                s_iters     = IW'(DELAY_MAG_W);
            end
            S_ADD: begin
                s_ctl.start = s_v_pos;
                s_x         = UW'(r_v[DELAY_MAG_W-1:0]);
                s_y         = UW'(r_v[DELAY_MAG_W-1:0]);
                s_iters     = IW'(DELAY_MAG_W);
            end
            S_MEAN: begin
                s_ctl.start = (r_npos != '0);
                s_ctl.op    = OP_DIV;
                s_x         = UW'({r_sum, {MEAN_FRAC{1'b0}}}) << (UW - SW - MEAN_FRAC);
                s_y         = UW'(r_npos);
                s_iters     = IW'(SW + MEAN_FRAC);
            end
            S_NSQ: begin
                s_ctl.start = 1'b1;
                s_x         = UW'(r_sq);
                s_y         = UW'(r_npos);
                s_iters     = IW'(CW);
            end
            S_SS: begin
                s_ctl.start = 1'b1;
                s_x         = UW'(r_sum);
                s_y         = UW'(r_sum);
                s_iters     = IW'(SW);
            end
            S_MM: begin
                s_ctl.start = 1'b1;
                s_x         = UW'(r_npos - CW'(1));
                s_y         = UW'(r_npos);
                s_iters     = IW'(CW);
            end
            S_VAR: begin
                s_ctl.start = 1'b1;
                s_ctl.op    = OP_DIV;
                s_x         = UW'({r_num, {VAR_FRAC{1'b0}}}) << (UW - NW - VAR_FRAC);
                s_y         = UW'(r_m);
                s_iters     = IW'(NW + VAR_FRAC);
            end
            S_SQRT: begin
                s_ctl.start = 1'b1;
                s_ctl.op    = OP_SQRT;
                s_x         = UW'(r_q);
                s_iters     = IW'(QW / 2);
            end
            S_RATE: begin
                s_ctl.start = (r_count != '0);
                s_ctl.op    = OP_DIV;
                s_x         = UW'({r_typo, {RATE_FRAC{1'b0}}}) << (UW - CW - RATE_FRAC);
                s_y         = UW'(r_count);
                s_iters     = IW'(CW + RATE_FRAC);
            end
            default: begin
                s_ctl.start = 1'b0;
            end
        endcase
    end

    wds_iter_unit #(
        .W (UW)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_iters  (s_iters),
        .i_x      (s_x),
        .i_y      (s_y),
        .o_result (s_result),
        .o_done   (s_done)
    );

    // window store
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            r_store[r_wpos] <= r_v;
        end
        r_rd_data <= r_store[s_rd_addr];
    end

    // architectural state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_newest    <= '0;
            r_count     <= '0;
            r_npos      <= '0;
            r_typo      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_def_mean  <= DEFAULT_MEAN_RST;
            r_def_stdev <= DEFAULT_STDEV_RST;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEFAULT_MEAN:  r_def_mean  <= i_cfg_data;
                    REG_DEFAULT_STDEV: r_def_stdev <= i_cfg_data;
                    default:           r_def_mean  <= r_def_mean;
                endcase
            end
            case (r_state)
                S_EVICT: begin
                    if (!s_old_pos) begin
                        r_typo <= r_typo - CW'(1);
                    end
                end
                S_EVW: begin
                    if (s_done) begin
                        r_npos <= r_npos - CW'(1);
                        r_sum  <= r_sum - SW'(r_rd_data[DELAY_MAG_W-1:0]);
                        r_sq   <= r_sq - SQW'(s_result[2*DELAY_MAG_W-1:0]);
                    end
                end
                S_ADD: begin
                    r_newest <= r_wpos;
                    if (!s_full) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (!s_v_pos) begin
                        r_typo <= r_typo + CW'(1);
                    end
                end
                S_ADDW: begin
                    if (s_done) begin
                        r_npos <= r_npos + CW'(1);
                        r_sum  <= r_sum + SW'(r_v[DELAY_MAG_W-1:0]);
                        r_sq   <= r_sq + SQW'(s_result[2*DELAY_MAG_W-1:0]);
                    end
                end
                default: begin
                    r_newest <= r_newest;
                end
            endcase
            if (r_state == S_DONE && s_out_room) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item payload and statistics
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    r_v <= i_s_tdata;
                end
            end
            S_CHK: begin
                r_accepted <= !s_drop;
                if (!s_drop) begin
                    r_wpos <= s_prev_pos;
                end
            end
            S_MEAN: begin
                if (r_npos == '0) begin
                    r_mean  <= {r_def_mean, {MEAN_FRAC{1'b0}}};
                    r_stdev <= {r_def_stdev, {MEAN_FRAC{1'b0}}};
                end
            end
            S_MEANW: begin
                if (s_done) begin
                    r_mean <= s_result[MEAN_W-1:0];
                    if (r_npos <= CW'(1)) begin
                        r_stdev <= {r_def_stdev, {MEAN_FRAC{1'b0}}};
                    end
                end
            end
            S_NSQW:  if (s_done) r_t1 <= s_result[NW-1:0];
            S_SSW:   if (s_done) r_num <= r_t1 - s_result[NW-1:0];
            S_MMW:   if (s_done) r_m <= s_result[MW-1:0];
            S_VARW:  if (s_done) r_q <= s_result[QW-1:0];
            S_SQRTW: if (s_done) r_stdev <= s_result[STDEV_W-1:0];
            S_RATE: begin
                if (r_count == '0) begin
                    r_rate <= '0;
                end
            end
            S_RATEW: if (s_done) r_rate <= s_result[RATE_W-1:0];
            S_DONE: begin
                if (s_out_room) begin
                    r_m_user <= r_accepted;
                    r_m_data <= {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                                 s_held32[HELD_W-1:0],
                                 s_cost32[COST_W-1:0],
                                 r_rate, r_stdev, r_mean};
                end
            end
            default: begin
                r_accepted <= r_accepted;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_counts_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (CW'(r_npos + r_typo) == r_count))
        else $error("positive and typo counts do not add up to held samples");

    a_empty_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_npos == '0) |-> (r_sum == '0 && r_sq == '0))
        else $error("sums nonzero with no positive delay held");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("shared unit finished outside an operation");
`endif

endmodule

`default_nettype wire
